@@ rtl/hrhc_pkg.sv @@
// Shared types, constants and per-byte update functions of the HTTP request head checker.
package hrhc_pkg;

	// Default width of the header line counter.
	localparam int COUNT_BITS_DEF = 8;

	// Character codes used by the parser.
	localparam logic [7:0] CH_SP    = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_STAR  = 8'h2A;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_ONE   = 8'h31;

	// Byte class codes.
	localparam logic [2:0] CLS_METHOD   = 3'd0;
	localparam logic [2:0] CLS_TARGET   = 3'd1;
	localparam logic [2:0] CLS_VERSION  = 3'd2;
	localparam logic [2:0] CLS_NAME     = 3'd3;
	localparam logic [2:0] CLS_VALUE    = 3'd4;
	localparam logic [2:0] CLS_SEP      = 3'd5;
	localparam logic [2:0] CLS_LINE_END = 3'd6;
	localparam logic [2:0] CLS_LWS      = 3'd7;

	// Error codes.
	localparam logic [2:0] ERR_NONE       = 3'd0;
	localparam logic [2:0] ERR_SPACES     = 3'd1;
	localparam logic [2:0] ERR_EMPTY      = 3'd2;
	localparam logic [2:0] ERR_TARGET     = 3'd3;
	localparam logic [2:0] ERR_VERSION    = 3'd4;
	localparam logic [2:0] ERR_EMPTY_LINE = 3'd5;
	localparam logic [2:0] ERR_NO_COLON   = 3'd6;
	localparam logic [2:0] ERR_BAD_NAME   = 3'd7;

	// Method codes.
	localparam logic [1:0] METH_UNKNOWN = 2'd0;

	// Method words: GET, HEAD, POST, and their lengths.
	localparam logic [7:0] METH_WORD [3][4] = '{
		'{8'h47, 8'h45, 8'h54, 8'h00},
		'{8'h48, 8'h45, 8'h41, 8'h44},
		'{8'h50, 8'h4F, 8'h53, 8'h54}
	};
	localparam logic [2:0] METH_LEN [3] = '{3'd3, 3'd4, 3'd4};

	// Version prefix "HTTP/1." followed by '0' or '1'.
	localparam logic [7:0] VER_PREFIX [7] = '{
		8'h48, 8'h54, 8'h54, 8'h50, 8'h2F, 8'h31, 8'h2E
	};
	localparam logic [3:0] VER_LEN = 4'd8;
	localparam logic [3:0] VER_IDX_MAX = 4'd9;

	// Parser phase, one-hot.
	typedef enum logic [5:0] {
		PH_METHOD  = 6'b000001,
		PH_TARGET  = 6'b000010,
		PH_VERSION = 6'b000100,
		PH_NAME    = 6'b001000,
		PH_LWS     = 6'b010000,
		PH_VALUE   = 6'b100000
	} phase_t;

	// Parser state apart from the header counter.
	typedef struct packed {
		phase_t     phase;
		logic [1:0] spaces;
		logic [2:0] m_cand;   // still matching GET, HEAD, POST
		logic [2:0] m_idx;    // method length, saturating at 7
		logic [2:0] t_info;   // bit0 not empty, bit1 starts with '/', bit2 is "*"
		logic       v_ok;
		logic [3:0] v_idx;    // version length, saturating at 9
		logic       cr_pend;
		logic [2:0] lf;       // bit0 data, bit1 colon, bit2 blank in name
		logic [2:0] first_err;
	} st_t;

	localparam st_t ST_RESET = '{
		phase:     PH_METHOD,
		spaces:    2'd0,
		m_cand:    3'b111,
		m_idx:     3'd0,
		t_info:    3'd0,
		v_ok:      1'b1,
		v_idx:     4'd0,
		cr_pend:   1'b0,
		lf:        3'd0,
		first_err: ERR_NONE
	};

	// State and class after one data byte.
	typedef struct packed {
		st_t        st;
		logic [2:0] cls;
	} db_res_t;

	// State after a line end, and whether a header line was accepted.
	typedef struct packed {
		st_t  st;
		logic inc;
	} el_res_t;

	// One result transfer.
	typedef struct packed {
		logic [7:0] byte_val;
		logic [2:0] cls;
		logic       cr_data;
		logic       line_done;
		logic       done;
		logic       ok;
		logic [2:0] err;
		logic [1:0] mcode;
		logic [7:0] total;
	} res_t;

	// Keep only the first error.
	function automatic st_t note_error(input st_t s, input logic [2:0] kind);
		st_t r;
		r = s;
		if (r.first_err == ERR_NONE) begin
			r.first_err = kind;
		end
		return r;
	endfunction

	// Narrow the method candidates by one byte.
	function automatic st_t method_update(input st_t s, input logic [7:0] b);
		st_t r;
		r = s;
		for (int k = 0; k < 3; k++) begin
			if (s.m_idx >= METH_LEN[k] || s.m_idx[2]) begin
				r.m_cand[k] = 1'b0;
			end else if (METH_WORD[k][s.m_idx[1:0]] != b) begin
				r.m_cand[k] = 1'b0;
			end
		end
		if (s.m_idx != 3'd7) begin
			r.m_idx = s.m_idx + 3'd1;
		end
		return r;
	endfunction

	// Match the version string by one byte.
	function automatic st_t version_update(input st_t s, input logic [7:0] b);
		st_t r;
		r = s;
		if (s.v_idx < 4'd7) begin
			r.v_ok = s.v_ok & (b == VER_PREFIX[s.v_idx[2:0]]);
		end else if (s.v_idx == 4'd7) begin
			r.v_ok = s.v_ok & (b == CH_ZERO || b == CH_ONE);
		end else begin
			r.v_ok = 1'b0;
		end
		if (s.v_idx < VER_IDX_MAX) begin
			r.v_idx = s.v_idx + 4'd1;
		end
		return r;
	endfunction

	// Apply one data byte to the current field.
	function automatic db_res_t data_byte(input st_t s, input logic [7:0] b);
		db_res_t r;
		logic    blank;
		r.st  = s;
		r.cls = CLS_VALUE;
		blank = (b == CH_SP) || (b == CH_TAB);
		case (s.phase)
			PH_METHOD: begin
				if (b == CH_SP) begin
					r.st.spaces = 2'd1;
					r.st.phase  = PH_TARGET;
					r.cls       = CLS_SEP;
				end else begin
					r.st  = method_update(s, b);
					r.cls = CLS_METHOD;
				end
			end
			PH_TARGET: begin
				if (b == CH_SP) begin
					r.st.spaces = 2'd2;
					r.st.phase  = PH_VERSION;
					r.cls       = CLS_SEP;
				end else begin
					if (!s.t_info[0]) begin
						r.st.t_info = {b == CH_STAR, b == CH_SLASH, 1'b1};
					end else begin
						r.st.t_info = s.t_info & 3'b011;
					end
					r.cls = CLS_TARGET;
				end
			end
			PH_VERSION: begin
				if (b == CH_SP) begin
					r.st.spaces = 2'd3;
					r.cls       = CLS_SEP;
				end else begin
					r.st  = version_update(s, b);
					r.cls = CLS_VERSION;
				end
			end
			PH_NAME: begin
				if (b == CH_COLON) begin
					if (!s.lf[0] || s.lf[2]) begin
						r.st = note_error(s, ERR_BAD_NAME);
					end
					r.st.lf    = s.lf | 3'b011;
					r.st.phase = PH_LWS;
					r.cls      = CLS_SEP;
				end else begin
					r.st.lf = s.lf | {blank, 1'b0, 1'b1};
					r.cls   = CLS_NAME;
				end
			end
			PH_LWS: begin
				if (blank) begin
					r.cls = CLS_LWS;
				end else begin
					r.st.phase = PH_VALUE;
					r.cls      = CLS_VALUE;
				end
			end
			default: begin
				r.cls = CLS_VALUE;
			end
		endcase
		return r;
	endfunction

	// Check the line that just ended and start a header line.
	function automatic el_res_t end_line(input st_t s);
		el_res_t r;
		r.st  = s;
		r.inc = 1'b0;
		if (s.phase == PH_METHOD || s.phase == PH_TARGET || s.phase == PH_VERSION) begin
			if (s.spaces != 2'd2) begin
				r.st = note_error(s, ERR_SPACES);
			end else if (s.m_idx == 3'd0 || !s.t_info[0]) begin
				r.st = note_error(s, ERR_EMPTY);
			end else if (s.t_info[2:1] == 2'b00) begin
				r.st = note_error(s, ERR_TARGET);
			end else if (!(s.v_ok && s.v_idx == VER_LEN)) begin
				r.st = note_error(s, ERR_VERSION);
			end
		end else begin
			if (!s.lf[0]) begin
				r.st = note_error(s, ERR_EMPTY_LINE);
			end else if (!s.lf[1]) begin
				r.st = note_error(s, ERR_NO_COLON);
			end else begin
				r.inc = (s.first_err == ERR_NONE);
			end
		end
		r.st.phase = PH_NAME;
		r.st.lf    = 3'd0;
		return r;
	endfunction

	// Method code from the final match state.
	function automatic logic [1:0] method_code_of(input st_t s);
		logic [1:0] code;
		code = METH_UNKNOWN;
		for (int k = 2; k >= 0; k--) begin
			if (s.m_cand[k] && s.m_idx == METH_LEN[k]) begin
				code = 2'(k + 1);
			end
		end
		return code;
	endfunction

endpackage

@@ rtl/hrhc_core.sv @@
// Parser state registers and the single-pass per-byte update logic.
module hrhc_core import hrhc_pkg::*; #(
	parameter int COUNT_BITS = COUNT_BITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       advance,
	input  logic [7:0] byte_val,
	input  logic       last,
	output res_t       res
);

	localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

	st_t                   st_q;
	logic [COUNT_BITS-1:0] count_q;

	st_t                   st_d;
	logic [COUNT_BITS-1:0] count_d;

	// Work out the result and next state for the byte in the input register.
	always_comb begin
		st_t                   s;
		db_res_t               d1;
		db_res_t               d2;
		el_res_t               e1;
		el_res_t               e2;
		logic [2:0]            cls;
		logic                  cr_data;
		logic                  closed;
		logic                  inc;
		logic [COUNT_BITS-1:0] count_n;

		s       = st_q;
		cls     = CLS_LINE_END;
		cr_data = 1'b0;
		closed  = 1'b0;
		inc     = 1'b0;
		d1      = '0;
		d2      = '0;
		e1      = '0;
		e2      = '0;

		if (st_q.cr_pend && byte_val == CH_LF) begin
			// CR LF closes the line.
			s.cr_pend = 1'b0;
			closed    = 1'b1;
			e1        = end_line(s);
			s         = e1.st;
			inc       = e1.inc;
		end else begin
			// A waiting CR without LF becomes data of its field.
			if (st_q.cr_pend) begin
				s.cr_pend = 1'b0;
				cr_data   = 1'b1;
				d1        = data_byte(s, CH_CR);
				s         = d1.st;
			end
			if (byte_val == CH_CR && !last) begin
				s.cr_pend = 1'b1;
				cls       = CLS_LINE_END;
			end else begin
				d2  = data_byte(s, byte_val);
				s   = d2.st;
				cls = d2.cls;
			end
		end

		// A head without a closing CR LF has its last line checked here.
		if (last && !closed) begin
			e2  = end_line(s);
			s   = e2.st;
			inc = e2.inc;
		end

		count_n = (inc && count_q != COUNT_MAX) ? count_q + 1'b1 : count_q;

		res.byte_val  = byte_val;
		res.cls       = cls;
		res.cr_data   = cr_data;
		res.line_done = closed;
		res.done      = last;
		res.ok        = last && (s.first_err == ERR_NONE);
		res.mcode     = (last && (s.first_err == ERR_NONE || s.first_err >= ERR_EMPTY_LINE))
			? method_code_of(s) : METH_UNKNOWN;
		res.err       = s.first_err;
		res.total     = (count_n > COUNT_BITS'(255)) ? 8'hFF : 8'(count_n);

		st_d    = last ? ST_RESET : s;
		count_d = last ? '0 : count_n;
	end

	// State advances once per byte moved out of the input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= ST_RESET;
			count_q <= '0;
		end else if (advance) begin
			st_q    <= st_d;
			count_q <= count_d;
		end
	end

endmodule

@@ rtl/http_request_head_checker_unit.sv @@
// Top level of the HTTP request head checker: input register, parser core, result register.
//
// Usage: request head bytes enter on the req channel (byte_in, last), one byte per
// transfer, with last set on the final byte of a head. For every byte, one result
// leaves on the res channel: the byte itself, its class, the CR-as-data and line-end
// flags, and on the final byte the verdict, first error, method code and header count.
// A transfer takes place on a rising clock edge where valid is high and stall is low.
//
// A byte from a req transfer is held in the input register and moves into the result
// register, raising res_valid, once that register is empty or its result is taken.
// The parser state is updated as a byte moves from the input register to the
// result register, so one byte per cycle is sustained while res_stall stays low.
// When res_stall is high, the result register holds; a byte may still enter the
// input register if it is empty, and req_stall rises once both registers are full.
// Reset clears all parser state and both valid flags; after the final byte of a head
// the parser returns to its reset state on its own, ready for the next head.
module http_request_head_checker_unit import hrhc_pkg::*; #(
	parameter int COUNT_BITS = COUNT_BITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       req_valid,
	output logic       req_stall,
	input  logic [7:0] byte_in,
	input  logic       last,
	output logic       res_valid,
	input  logic       res_stall,
	output logic [7:0] byte_out,
	output logic [2:0] byte_class,
	output logic       cr_was_data,
	output logic       line_done,
	output logic       done_res,
	output logic       head_ok,
	output logic [2:0] error_kind,
	output logic [1:0] method_code,
	output logic [7:0] header_total
);

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;
	logic       valid_s2;
	res_t       res_s2;

	res_t       res_c;
	logic       open_s2;
	logic       adv_s2;

	// Stage two moves when empty or when its result is taken.
	assign open_s2   = !valid_s2 || !res_stall;
	assign adv_s2    = valid_s1 && open_s2;
	assign req_stall = valid_s1 && !open_s2;

	hrhc_core #(
		.COUNT_BITS(COUNT_BITS)
	) u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (adv_s2),
		.byte_val(byte_s1),
		.last    (last_s1),
		.res     (res_c)
	);

	// Valid flags of both stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (!req_stall) begin
				valid_s1 <= req_valid;
			end
			if (open_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	// Input register payload.
	always_ff @(posedge clk) begin
		if (!req_stall && req_valid) begin
			byte_s1 <= byte_in;
			last_s1 <= last;
		end
	end

	// Result register payload.
	always_ff @(posedge clk) begin
		if (adv_s2) begin
			res_s2 <= res_c;
		end
	end

	assign res_valid    = valid_s2;
	assign byte_out     = res_s2.byte_val;
	assign byte_class   = res_s2.cls;
	assign cr_was_data  = res_s2.cr_data;
	assign line_done    = res_s2.line_done;
	assign done_res     = res_s2.done;
	assign head_ok      = res_s2.ok;
	assign error_kind   = res_s2.err;
	assign method_code  = res_s2.mcode;
	assign header_total = res_s2.total;

endmodule

@@ rtl/hrhc_checker.sv @@
// Port-level checker for the HTTP request head checker, bound to its top level.
module hrhc_checker import hrhc_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       req_valid,
	input logic       req_stall,
	input logic [7:0] byte_in,
	input logic       last,
	input logic       res_valid,
	input logic       res_stall,
	input logic [7:0] byte_out,
	input logic [2:0] byte_class,
	input logic       cr_was_data,
	input logic       line_done,
	input logic       done_res,
	input logic       head_ok,
	input logic [2:0] error_kind,
	input logic [1:0] method_code,
	input logic [7:0] header_total
);

	// A stalled result holds until it is taken.
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(byte_out) && $stable(byte_class)
			&& $stable(done_res) && $stable(error_kind))
		else $error("result changed while stalled");

	// The verdict on the final byte agrees with the error code.
	a_verdict: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && done_res |-> head_ok == (error_kind == ERR_NONE))
		else $error("head_ok disagrees with error_kind");

	// Verdict and method code stay zero before the final byte.
	a_not_final: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !done_res |-> !head_ok && method_code == METH_UNKNOWN)
		else $error("verdict shown before the final byte");

	// A closed line is always an LF tagged as line end.
	a_line_end: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && line_done |-> byte_out == CH_LF && byte_class == CLS_LINE_END)
		else $error("line_done on a byte that is not a line-end LF");

endmodule

bind http_request_head_checker_unit hrhc_checker u_hrhc_checker (.*);
